@@ rtl/afd_pkg.sv @@
// Package for the accelerometer fall detector: item structs, codes and
// reset values shared by the lanes, the register file and the merge stage.
// No dependencies.
package afd_pkg;

  // Width of the wrapping millisecond time base.
  localparam int unsigned TIME_BITS = 32;
  typedef logic [TIME_BITS-1:0] stamp_t;

  // Squared-threshold widths: a 15-bit value squared needs 30 bits,
  // a 16-bit signed axis value squared needs 31 bits.
  localparam int unsigned THR_BITS = 15;
  localparam int unsigned THR_SQ_BITS = 2 * THR_BITS;
  localparam int unsigned AXIS_SQ_BITS = 31;
  localparam int unsigned SUM_SQ_BITS = 32;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_CLEAR  = 2'd2
  } afd_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FREE   = 3'd1,
    PH_IMPACT = 3'd2,
    PH_STILL  = 3'd3,
    PH_CONF   = 3'd4,
    PH_CANC   = 3'd5
  } afd_phase_e;

  typedef enum logic [7:0] {
    REG_FF_THRESH  = 8'd0,
    REG_IM_THRESH  = 8'd1,
    REG_ST_THRESH  = 8'd2,
    REG_STILL_DUR  = 8'd3,
    REG_CANCEL_WIN = 8'd4,
    REG_MIN_FF     = 8'd5,
    REG_FF_TIMEOUT = 8'd6,
    REG_IMPACT_WIN = 8'd7
  } afd_reg_e;

  // Register reset values.
  localparam int unsigned FF_THRESH_RST  = 350;
  localparam int unsigned IM_THRESH_RST  = 2500;
  localparam int unsigned ST_THRESH_RST  = 1200;
  localparam logic [15:0] STILL_DUR_RST  = 16'd2000;
  localparam logic [15:0] CANCEL_WIN_RST = 16'd10000;
  localparam logic [15:0] MIN_FF_RST     = 16'd80;
  localparam logic [15:0] FF_TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] IMPACT_WIN_RST = 16'd500;

  localparam logic [THR_SQ_BITS-1:0] FF_SQ_RST = THR_SQ_BITS'(FF_THRESH_RST * FF_THRESH_RST);
  localparam logic [THR_SQ_BITS-1:0] IM_SQ_RST = THR_SQ_BITS'(IM_THRESH_RST * IM_THRESH_RST);
  localparam logic [THR_SQ_BITS-1:0] ST_SQ_RST = THR_SQ_BITS'(ST_THRESH_RST * ST_THRESH_RST);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        timestamp_ms;
  } afd_in_t;

  typedef struct packed {
    logic [2:0]         detector_state;
    logic               fall_detected;
    logic               fall_cancelled;
    logic [15:0]        falls_so_far;
    logic signed [15:0] peak_axis_mg;
  } afd_out_t;

  // Configuration as seen by the merge stage: thresholds already squared.
  typedef struct packed {
    logic [THR_SQ_BITS-1:0] ff_sq;
    logic [THR_SQ_BITS-1:0] im_sq;
    logic [THR_SQ_BITS-1:0] st_sq;
    logic [15:0]            still_dur;
    logic [15:0]            cancel_win;
    logic [15:0]            min_ff;
    logic [15:0]            ff_timeout;
    logic [15:0]            impact_win;
  } afd_cfg_t;

endpackage

@@ rtl/afd_lane.sv @@
// One axis lane of the fall detector: registers the axis value and its square.
// Depends on afd_pkg.
module afd_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [15:0]                   accel_i,
  output logic signed [15:0]                   accel_o,
  output logic [afd_pkg::AXIS_SQ_BITS-1:0]     square_o
);

  logic signed [31:0] product;

  assign product = accel_i * accel_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      accel_o  <= accel_i;
      square_o <= product[afd_pkg::AXIS_SQ_BITS-1:0];
    end
  end

endmodule

@@ rtl/afd_cfg.sv @@
// Configuration registers of the fall detector; magnitude thresholds are
// squared when written. Depends on afd_pkg.
module afd_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [7:0]        index_i,
  input  logic [15:0]       data_i,
  output afd_pkg::afd_cfg_t cfg_o
);

  afd_pkg::afd_cfg_t cfg_q, cfg_d;
  logic [afd_pkg::THR_BITS-1:0]    thr;
  logic [afd_pkg::THR_SQ_BITS-1:0] thr_sq;

  assign thr    = data_i[afd_pkg::THR_BITS-1:0];
  assign thr_sq = thr * thr;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (index_i)
        afd_pkg::REG_FF_THRESH:  cfg_d.ff_sq      = thr_sq;
        afd_pkg::REG_IM_THRESH:  cfg_d.im_sq      = thr_sq;
        afd_pkg::REG_ST_THRESH:  cfg_d.st_sq      = thr_sq;
        afd_pkg::REG_STILL_DUR:  cfg_d.still_dur  = data_i;
        afd_pkg::REG_CANCEL_WIN: cfg_d.cancel_win = data_i;
        afd_pkg::REG_MIN_FF:     cfg_d.min_ff     = data_i;
        afd_pkg::REG_FF_TIMEOUT: cfg_d.ff_timeout = data_i;
        afd_pkg::REG_IMPACT_WIN: cfg_d.impact_win = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ff_sq      <= afd_pkg::FF_SQ_RST;
      cfg_q.im_sq      <= afd_pkg::IM_SQ_RST;
      cfg_q.st_sq      <= afd_pkg::ST_SQ_RST;
      cfg_q.still_dur  <= afd_pkg::STILL_DUR_RST;
      cfg_q.cancel_win <= afd_pkg::CANCEL_WIN_RST;
      cfg_q.min_ff     <= afd_pkg::MIN_FF_RST;
      cfg_q.ff_timeout <= afd_pkg::FF_TIMEOUT_RST;
      cfg_q.impact_win <= afd_pkg::IMPACT_WIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/afd_merge.sv @@
// Merge stage of the fall detector: sums the lane squares, compares them with
// the squared thresholds and runs the detection state machine.
// Depends on afd_pkg.
module afd_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic [1:0]                       kind_i,
  input  logic [31:0]                      stamp_i,
  input  logic signed [15:0]               ax_i,
  input  logic signed [15:0]               ay_i,
  input  logic signed [15:0]               az_i,
  input  logic [afd_pkg::AXIS_SQ_BITS-1:0] sx_i,
  input  logic [afd_pkg::AXIS_SQ_BITS-1:0] sy_i,
  input  logic [afd_pkg::AXIS_SQ_BITS-1:0] sz_i,
  input  afd_pkg::afd_cfg_t                cfg_i,
  output afd_pkg::afd_out_t                out_o
);

  afd_pkg::afd_phase_e phase_q, phase_d;
  afd_pkg::stamp_t     entry_q, entry_d;
  afd_pkg::stamp_t     ffstart_q, ffstart_d;
  logic [15:0]         falls_q, falls_d;
  logic signed [15:0]  peak_q, peak_d;
  logic [afd_pkg::AXIS_SQ_BITS-1:0] peak_sq_q, peak_sq_d;
  afd_pkg::afd_out_t   out_q;

  afd_pkg::stamp_t     now, since_entry, since_ff;
  logic [afd_pkg::SUM_SQ_BITS-1:0] sum_sq;
  logic is_sample, is_cancel, is_clear;
  logic lt_ff, ge_im, lt_st, gt_pk, short_ff;
  logic detect, cancel, peak_upd;
  logic signed [15:0] max_axis;
  logic [afd_pkg::AXIS_SQ_BITS-1:0] max_sq;

  assign now         = afd_pkg::stamp_t'(stamp_i);
  assign since_entry = now - entry_q;
  assign since_ff    = now - ffstart_q;

  assign sum_sq = afd_pkg::SUM_SQ_BITS'(sx_i) + afd_pkg::SUM_SQ_BITS'(sy_i)
                + afd_pkg::SUM_SQ_BITS'(sz_i);

  assign lt_ff    = sum_sq <  afd_pkg::SUM_SQ_BITS'(cfg_i.ff_sq);
  assign ge_im    = sum_sq >= afd_pkg::SUM_SQ_BITS'(cfg_i.im_sq);
  assign lt_st    = sum_sq <  afd_pkg::SUM_SQ_BITS'(cfg_i.st_sq);
  assign gt_pk    = sum_sq >  afd_pkg::SUM_SQ_BITS'(peak_sq_q);
  assign short_ff = since_ff < afd_pkg::stamp_t'(cfg_i.min_ff);

  assign is_sample = (kind_i == afd_pkg::KIND_SAMPLE);
  assign is_cancel = (kind_i == afd_pkg::KIND_CANCEL);
  assign is_clear  = (kind_i == afd_pkg::KIND_CLEAR);

  // Largest axis value, with its square picked from the matching lane.
  always_comb begin
    if (ax_i > ay_i) begin
      if (ax_i > az_i) begin
        max_axis = ax_i;
        max_sq   = sx_i;
      end else begin
        max_axis = az_i;
        max_sq   = sz_i;
      end
    end else begin
      if (ay_i > az_i) begin
        max_axis = ay_i;
        max_sq   = sy_i;
      end else begin
        max_axis = az_i;
        max_sq   = sz_i;
      end
    end
  end

  assign detect = is_sample && (phase_q == afd_pkg::PH_STILL) && lt_st
               && (since_entry >= afd_pkg::stamp_t'(cfg_i.still_dur));
  assign cancel = is_cancel && (phase_q == afd_pkg::PH_CONF);
  assign peak_upd = is_sample && (phase_q == afd_pkg::PH_FREE) && !lt_ff
                 && !short_ff && ge_im && gt_pk;

  // Next state and phase entry times.
  always_comb begin
    phase_d   = phase_q;
    entry_d   = entry_q;
    ffstart_d = ffstart_q;
    if (is_sample) begin
      case (phase_q)
        afd_pkg::PH_IDLE: begin
          if (lt_ff) begin
            phase_d   = afd_pkg::PH_FREE;
            entry_d   = now;
            ffstart_d = now;
          end
        end
        afd_pkg::PH_FREE: begin
          if (!lt_ff) begin
            entry_d = now;
            if (!short_ff && ge_im) begin
              phase_d = afd_pkg::PH_IMPACT;
            end else begin
              phase_d = afd_pkg::PH_IDLE;
            end
          end else if (since_entry > afd_pkg::stamp_t'(cfg_i.ff_timeout)) begin
            phase_d = afd_pkg::PH_IDLE;
            entry_d = now;
          end
        end
        afd_pkg::PH_IMPACT: begin
          if (lt_st) begin
            phase_d = afd_pkg::PH_STILL;
            entry_d = now;
          end else if (since_entry > afd_pkg::stamp_t'(cfg_i.impact_win)) begin
            phase_d = afd_pkg::PH_IDLE;
            entry_d = now;
          end
        end
        afd_pkg::PH_STILL: begin
          if (!lt_st) begin
            phase_d = afd_pkg::PH_IDLE;
            entry_d = now;
          end else if (detect) begin
            phase_d = afd_pkg::PH_CONF;
            entry_d = now;
          end
        end
        afd_pkg::PH_CONF: begin
          if (since_entry > afd_pkg::stamp_t'(cfg_i.cancel_win)) begin
            phase_d = afd_pkg::PH_IDLE;
            entry_d = now;
          end
        end
        default: begin
          phase_d = afd_pkg::PH_IDLE;
          entry_d = now;
        end
      endcase
    end else if (cancel) begin
      phase_d = afd_pkg::PH_CANC;
      entry_d = now;
    end
  end

  // Fall count and peak estimate.
  always_comb begin
    falls_d   = falls_q;
    peak_d    = peak_q;
    peak_sq_d = peak_sq_q;
    if (is_clear) begin
      falls_d = '0;
    end else if (detect && (falls_q != 16'hFFFF)) begin
      falls_d = falls_q + 16'd1;
    end
    if (peak_upd) begin
      peak_d    = max_axis;
      peak_sq_d = max_sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= afd_pkg::PH_IDLE;
      entry_q   <= '0;
      ffstart_q <= '0;
      falls_q   <= '0;
      peak_q    <= '0;
      peak_sq_q <= '0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      entry_q   <= entry_d;
      ffstart_q <= ffstart_d;
      falls_q   <= falls_d;
      peak_q    <= peak_d;
      peak_sq_q <= peak_sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.detector_state <= 3'(phase_d);
      out_q.fall_detected  <= detect;
      out_q.fall_cancelled <= cancel;
      out_q.falls_so_far   <= falls_d;
      out_q.peak_axis_mg   <= peak_d;
    end
  end

  assign out_o = out_q;

endmodule

@@ rtl/accel_fall_detector.sv @@
// Top level of the accelerometer fall detector.
// Depends on afd_pkg, afd_lane, afd_cfg and afd_merge.

// The detector takes one item per clock cycle, sustained, while the output side
// is ready, and returns exactly one result item for each, once the item has
// passed the lane register and the result register. An item is a timestamped
// three-axis sample, a user cancel or a clear of the fall count. First three
// axis lanes square their values in parallel; then the merge stage sums the
// squares, compares the sum with the squared thresholds and advances the state
// machine (idle, free fall, impact, stillness, confirmed, cancelled). That
// state update closes on itself, which is what fixes the rate at one item per
// cycle. The result register and the lane register form a two-deep pipeline, so
// a new item is taken while a finished result waits. Configuration writes are
// always accepted; magnitude thresholds are squared as they are written, and
// registers should be written only while no item is in flight. There is no
// memory and no clearing pass after reset.
module accel_fall_detector (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  afd_pkg::afd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output afd_pkg::afd_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  afd_pkg::afd_cfg_t cfg;

  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_accept, out_free, s1_adv;

  // Lane-stage copies of the non-axis fields.
  logic [1:0]  kind_q;
  logic [31:0] stamp_q;

  logic signed [15:0] ax, ay, az;
  logic [afd_pkg::AXIS_SQ_BITS-1:0] sx, sy, sz;

  // The result register is free when empty or being drained this cycle; the
  // lane stage moves forward whenever the result register is free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= in_data_i.kind;
      stamp_q <= in_data_i.timestamp_ms;
    end
  end

  afd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  afd_lane u_lane_x (
    .clk_i    (clk_i),
    .en_i     (in_accept),
    .accel_i  (in_data_i.accel_x),
    .accel_o  (ax),
    .square_o (sx)
  );

  afd_lane u_lane_y (
    .clk_i    (clk_i),
    .en_i     (in_accept),
    .accel_i  (in_data_i.accel_y),
    .accel_o  (ay),
    .square_o (sy)
  );

  afd_lane u_lane_z (
    .clk_i    (clk_i),
    .en_i     (in_accept),
    .accel_i  (in_data_i.accel_z),
    .accel_o  (az),
    .square_o (sz)
  );

  afd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .kind_i  (kind_q),
    .stamp_i (stamp_q),
    .ax_i    (ax),
    .ay_i    (ay),
    .az_i    (az),
    .sx_i    (sx),
    .sy_i    (sy),
    .sz_i    (sz),
    .cfg_i   (cfg),
    .out_o   (out_data_o)
  );

  assign out_valid_o = out_valid_q;

  // A detection is only reported together with the confirmed state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fall_detected
      |-> out_data_o.detector_state == 3'(afd_pkg::PH_CONF))
    else $error("fall reported outside the confirmed state");

  // A cancellation is only reported together with the cancelled state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fall_cancelled
      |-> out_data_o.detector_state == 3'(afd_pkg::PH_CANC))
    else $error("cancel reported outside the cancelled state");

  // An accepted item always lands in the lane stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted item lost before the lane stage");

  // With both stages full and the output stalled, no new item may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("lane stage would be overwritten while stalled");

endmodule

@@ verif/accel_fall_detector_tb.sv @@
// Self-checking testbench for accel_fall_detector: directed rows followed by
// steered random fall sequences under several register settings.
// Depends on afd_pkg and the accel_fall_detector RTL.
module testbench;

  // The watchdog is sized from the slowest correct run: some 410 items, each
  // with its longest random gaps, plus the long hold-off, the register writes
  // and the drains. The limit is several times that sum.
  localparam int unsigned CYCLE_LIMIT     = 100_000;
  localparam int unsigned MAX_WAIT        = 14;
  localparam int unsigned HOLD_OFF_AT     = 150;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned NUM_REGS        = 8;
  localparam int unsigned INDEX_MAX       = 255;
  localparam int unsigned IDLE_SPAN       = 50;
  localparam logic [1:0]  KIND_UNKNOWN    = 2'd3;
  localparam logic [15:0] FALLS_MAX       = 16'hFFFF;

  typedef struct {
    afd_pkg::afd_in_t  item;
    bit                typed;
    afd_pkg::afd_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  afd_pkg::afd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  afd_pkg::afd_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // When calm is set, neither side inserts any idle cycles.
  bit calm = 1'b0;
  int unsigned error_count = 0;
  logic [31:0] stamp_now = 32'd2000;

  afd_pkg::afd_out_t pending_results[$];
  stim_row_t         directed_rows[$];

  accel_fall_detector DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: its own copy of the detector state and of the register file.
  // --------------------------------------------------------------------------
  logic [14:0] thr_ff = 15'(afd_pkg::FF_THRESH_RST);
  logic [14:0] thr_im = 15'(afd_pkg::IM_THRESH_RST);
  logic [14:0] thr_st = 15'(afd_pkg::ST_THRESH_RST);
  logic [15:0] cfg_still_dur  = afd_pkg::STILL_DUR_RST;
  logic [15:0] cfg_cancel_win = afd_pkg::CANCEL_WIN_RST;
  logic [15:0] cfg_min_ff     = afd_pkg::MIN_FF_RST;
  logic [15:0] cfg_ff_timeout = afd_pkg::FF_TIMEOUT_RST;
  logic [15:0] cfg_impact_win = afd_pkg::IMPACT_WIN_RST;

  afd_pkg::afd_phase_e pred_phase = afd_pkg::PH_IDLE;
  logic [31:0]        pred_entry = '0;
  logic [31:0]        pred_ff_start = '0;
  logic [15:0]        pred_falls = '0;
  logic signed [15:0] pred_peak = '0;

  function automatic void enter_phase(input afd_pkg::afd_phase_e p,
                                      input logic [31:0] now);
    pred_phase = p;
    pred_entry = now;
  endfunction

  // Magnitude thresholds keep 15 bits of the written word; the others keep 16.
  // Writes to indexes past the last register change nothing.
  function automatic void apply_config(input logic [7:0] idx, input logic [15:0] val);
    case (idx)
      afd_pkg::REG_FF_THRESH:  thr_ff = val[14:0];
      afd_pkg::REG_IM_THRESH:  thr_im = val[14:0];
      afd_pkg::REG_ST_THRESH:  thr_st = val[14:0];
      afd_pkg::REG_STILL_DUR:  cfg_still_dur = val;
      afd_pkg::REG_CANCEL_WIN: cfg_cancel_win = val;
      afd_pkg::REG_MIN_FF:     cfg_min_ff = val;
      afd_pkg::REG_FF_TIMEOUT: cfg_ff_timeout = val;
      afd_pkg::REG_IMPACT_WIN: cfg_impact_win = val;
      default: ;
    endcase
  endfunction

  // Advances the predicted state by one accepted item and returns the result
  // that the detector must produce for it.
  function automatic afd_pkg::afd_out_t predict_detector(input afd_pkg::afd_in_t it);
    afd_pkg::afd_out_t res;
    longint      ax, ay, az, mag_sq, ff_sq, im_sq, st_sq, pk, top;
    logic [31:0] now, elapsed;
    bit          detected, cancelled, short_fall;
    ax = $signed(it.accel_x);
    ay = $signed(it.accel_y);
    az = $signed(it.accel_z);
    now = it.timestamp_ms;
    detected = 1'b0;
    cancelled = 1'b0;
    short_fall = 1'b0;
    mag_sq = ax * ax + ay * ay + az * az;
    ff_sq = longint'(thr_ff) * longint'(thr_ff);
    im_sq = longint'(thr_im) * longint'(thr_im);
    st_sq = longint'(thr_st) * longint'(thr_st);
    case (it.kind)
      afd_pkg::KIND_SAMPLE: begin
        case (pred_phase)
          afd_pkg::PH_IDLE: begin
            if (mag_sq < ff_sq) begin
              enter_phase(afd_pkg::PH_FREE, now);
              pred_ff_start = now;
            end
          end
          afd_pkg::PH_FREE: begin
            if (mag_sq >= ff_sq) begin
              elapsed = now - pred_ff_start;
              if (elapsed < {16'd0, cfg_min_ff}) begin
                // A free fall that ends too soon does not count.
                enter_phase(afd_pkg::PH_IDLE, now);
                short_fall = 1'b1;
              end else if (mag_sq >= im_sq) begin
                // The stored peak is the largest axis value, not the magnitude.
                pk = pred_peak;
                if (mag_sq > pk * pk) begin
                  top = (ax > ay) ? ((ax > az) ? ax : az) : ((ay > az) ? ay : az);
                  pred_peak = top[15:0];
                end
                enter_phase(afd_pkg::PH_IMPACT, now);
              end else begin
                enter_phase(afd_pkg::PH_IDLE, now);
              end
            end
            // The timeout looks at the entry time, which a transition above
            // has just moved to now.
            elapsed = now - pred_entry;
            if (!short_fall && elapsed > {16'd0, cfg_ff_timeout}) begin
              enter_phase(afd_pkg::PH_IDLE, now);
            end
          end
          afd_pkg::PH_IMPACT: begin
            elapsed = now - pred_entry;
            if (mag_sq < st_sq) begin
              enter_phase(afd_pkg::PH_STILL, now);
            end else if (elapsed > {16'd0, cfg_impact_win}) begin
              enter_phase(afd_pkg::PH_IDLE, now);
            end
          end
          afd_pkg::PH_STILL: begin
            elapsed = now - pred_entry;
            if (mag_sq >= st_sq) begin
              enter_phase(afd_pkg::PH_IDLE, now);
            end else if (elapsed >= {16'd0, cfg_still_dur}) begin
              enter_phase(afd_pkg::PH_CONF, now);
              if (pred_falls != FALLS_MAX) pred_falls = pred_falls + 16'd1;
              detected = 1'b1;
            end
          end
          afd_pkg::PH_CONF: begin
            elapsed = now - pred_entry;
            if (elapsed > {16'd0, cfg_cancel_win}) enter_phase(afd_pkg::PH_IDLE, now);
          end
          default: enter_phase(afd_pkg::PH_IDLE, now);
        endcase
      end
      afd_pkg::KIND_CANCEL: begin
        if (pred_phase == afd_pkg::PH_CONF) begin
          enter_phase(afd_pkg::PH_CANC, now);
          cancelled = 1'b1;
        end
      end
      afd_pkg::KIND_CLEAR: pred_falls = '0;
      default: ;
    endcase
    res.detector_state = pred_phase;
    res.fall_detected = detected;
    res.fall_cancelled = cancelled;
    res.falls_so_far = pred_falls;
    res.peak_axis_mg = pred_peak;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation.
  // --------------------------------------------------------------------------
  // One axis value small enough that three of them stay below thr squared when thr is nonzero.
  function automatic logic signed [15:0] axis_within(input int unsigned thr);
    logic signed [15:0] v;
    v = 16'($urandom_range(0, thr / 2));
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // One axis value whose square alone reaches thr squared.
  function automatic logic signed [15:0] axis_beyond(input int unsigned thr);
    logic signed [15:0] v;
    v = 16'($urandom_range(thr, 32767));
    if ($urandom_range(0, 1)) v = -v;
    if ($urandom_range(0, 7) == 0) v = 16'sh8000;
    return v;
  endfunction

  // Time steps cluster around the duration that matters in the current phase,
  // hitting just below, at and just above it; a few are long jumps.
  function automatic logic [31:0] time_step(input int unsigned span);
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'($urandom_range(0, 20));
      2, 3:    return 32'($urandom_range(0, span));
      4:       return 32'(span);
      5:       return 32'(span + 1);
      9:       return 32'(span) - 32'd1;
      10:      return $urandom_range(0, 1) ? $urandom : 32'(span);
      default: return 32'($urandom_range(0, 2 * span + 2));
    endcase
  endfunction

  // Most items are steered by the predicted phase so that complete fall
  // sequences happen often; the rest are cancels, clears, unknown kinds and
  // unsteered samples.
  function automatic afd_pkg::afd_in_t next_random_item();
    afd_pkg::afd_in_t it;
    int unsigned span, pick, shape;
    case (pred_phase)
      afd_pkg::PH_IDLE:   span = IDLE_SPAN;
      afd_pkg::PH_FREE:   span = $urandom_range(0, 1) ? cfg_min_ff : cfg_ff_timeout;
      afd_pkg::PH_IMPACT: span = cfg_impact_win;
      afd_pkg::PH_STILL:  span = cfg_still_dur;
      afd_pkg::PH_CONF:   span = cfg_cancel_win;
      default:            span = 20;
    endcase
    stamp_now = stamp_now + time_step(span);
    it.timestamp_ms = stamp_now;
    it.accel_x = 16'($urandom);
    it.accel_y = 16'($urandom);
    it.accel_z = 16'($urandom);
    it.kind = afd_pkg::KIND_SAMPLE;
    pick = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    if (pred_phase == afd_pkg::PH_CONF && pick < 25) begin
      it.kind = afd_pkg::KIND_CANCEL;
    end else if (pick < 4) begin
      it.kind = afd_pkg::KIND_CANCEL;
    end else if (pick < 8) begin
      it.kind = afd_pkg::KIND_CLEAR;
    end else if (pick < 11) begin
      it.kind = KIND_UNKNOWN;
    end else begin
      case (pred_phase)
        afd_pkg::PH_IDLE: begin
          if (shape < 7) begin
            it.accel_x = axis_within(thr_ff);
            it.accel_y = axis_within(thr_ff);
            it.accel_z = axis_within(thr_ff);
          end
        end
        afd_pkg::PH_FREE: begin
          if (shape < 5) begin
            case ($urandom_range(0, 2))
              0:       it.accel_x = axis_beyond(thr_im);
              1:       it.accel_y = axis_beyond(thr_im);
              default: it.accel_z = axis_beyond(thr_im);
            endcase
          end else if (shape < 7) begin
            it.accel_x = axis_within(thr_ff);
            it.accel_y = axis_within(thr_ff);
            it.accel_z = axis_within(thr_ff);
          end else if (shape < 9) begin
            it.accel_x = axis_within(thr_im);
            it.accel_y = axis_within(thr_im);
            it.accel_z = axis_within(thr_im);
          end
        end
        afd_pkg::PH_IMPACT, afd_pkg::PH_STILL: begin
          if (shape < 8) begin
            it.accel_x = axis_within(thr_st);
            it.accel_y = axis_within(thr_st);
            it.accel_z = axis_within(thr_st);
          end
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic afd_pkg::afd_in_t make_item(input logic [1:0] kind,
                                                 input logic signed [15:0] x,
                                                 input logic signed [15:0] y,
                                                 input logic signed [15:0] z,
                                                 input logic [31:0] t);
    afd_pkg::afd_in_t it;
    it.kind = kind;
    it.accel_x = x;
    it.accel_y = y;
    it.accel_z = z;
    it.timestamp_ms = t;
    return it;
  endfunction

  function automatic afd_pkg::afd_out_t make_result(input afd_pkg::afd_phase_e ph,
                                                    input bit det, input bit canc,
                                                    input logic [15:0] falls,
                                                    input logic signed [15:0] peak);
    afd_pkg::afd_out_t r;
    r.detector_state = ph;
    r.fall_detected = det;
    r.fall_cancelled = canc;
    r.falls_so_far = falls;
    r.peak_axis_mg = peak;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic signed [15:0] x,
                         input logic signed [15:0] y, input logic signed [15:0] z,
                         input logic [31:0] t);
    stim_row_t row;
    row.item = make_item(kind, x, y, z, t);
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [1:0] kind, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z,
                           input logic [31:0] t, input afd_pkg::afd_out_t want);
    stim_row_t row;
    row.item = make_item(kind, x, y, z, t);
    row.typed = 1'b1;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; handshakes are sampled on the
  // rising edge. Valid stays high from one item to the next when there is no
  // gap, so each signal gets a single assignment per time step.
  // --------------------------------------------------------------------------
  task automatic send_item(input afd_pkg::afd_in_t it, input bit typed,
                           input afd_pkg::afd_out_t want);
    int unsigned       gap;
    afd_pkg::afd_out_t predicted;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    // The predictor runs for every row, so its state tracks the detector
    // even where the expected result is typed into the table.
    predicted = predict_detector(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_item(next_random_item(), 1'b0, '0);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_config(idx, val);
  endtask

  // Writes every register, then one index past the end that must be ignored.
  task automatic write_all(input logic [15:0] ff, input logic [15:0] im,
                           input logic [15:0] st, input logic [15:0] still_dur,
                           input logic [15:0] cancel_win, input logic [15:0] min_ff,
                           input logic [15:0] ff_timeout, input logic [15:0] impact_win);
    cfg_write(afd_pkg::REG_FF_THRESH, ff);
    cfg_write(afd_pkg::REG_IM_THRESH, im);
    cfg_write(afd_pkg::REG_ST_THRESH, st);
    cfg_write(afd_pkg::REG_STILL_DUR, still_dur);
    cfg_write(afd_pkg::REG_CANCEL_WIN, cancel_win);
    cfg_write(afd_pkg::REG_MIN_FF, min_ff);
    cfg_write(afd_pkg::REG_FF_TIMEOUT, ff_timeout);
    cfg_write(afd_pkg::REG_IMPACT_WIN, impact_win);
    cfg_write(8'($urandom_range(NUM_REGS, INDEX_MAX)), 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Realistic thresholds with short durations, so sequences complete quickly.
  task automatic write_moderate();
    write_all(16'($urandom_range(200, 900)), 16'($urandom_range(1500, 6000)),
              16'($urandom_range(600, 2500)), 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 400)), 16'($urandom_range(0, 100)),
              16'($urandom_range(50, 600)), 16'($urandom_range(20, 300)));
  endtask

  // Stops offering items and waits until every expected result has arrived.
  // Each item yields a result, so the settle wait after that is only margin.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, one long hold-off, and the checks.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned       wait_cycles;
    int unsigned       received;
    afd_pkg::afd_out_t want;
    afd_pkg::afd_out_t got;
    received = 0;
    forever begin
      if (received == HOLD_OFF_AT) begin
        // Hold off long enough that the two-deep pipeline fills and the
        // input side stalls while the sender keeps offering items.
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end
      wait_cycles = calm ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (wait_cycles) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      received++;
      if (pending_results.size() == 0) begin
        $error("result item arrived with no expected result waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.detector_state !== want.detector_state) begin
          $error("detector_state: expected %0d, got %0d",
                 want.detector_state, got.detector_state);
          error_count++;
        end
        if (got.fall_detected !== want.fall_detected) begin
          $error("fall_detected: expected %0d, got %0d",
                 want.fall_detected, got.fall_detected);
          error_count++;
        end
        if (got.fall_cancelled !== want.fall_cancelled) begin
          $error("fall_cancelled: expected %0d, got %0d",
                 want.fall_cancelled, got.fall_cancelled);
          error_count++;
        end
        if (got.falls_so_far !== want.falls_so_far) begin
          $error("falls_so_far: expected %0d, got %0d",
                 want.falls_so_far, got.falls_so_far);
          error_count++;
        end
        if (got.peak_axis_mg !== want.peak_axis_mg) begin
          $error("peak_axis_mg: expected %0d, got %0d",
                 want.peak_axis_mg, got.peak_axis_mg);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles and ends a run that hangs.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows with the reset configuration. Results that follow plainly
    // from the reset values are typed in; the rest come from the predictor.
    // Quiet sample, cancel in idle, unknown kind and clear leave idle alone.
    add_typed(afd_pkg::KIND_SAMPLE, 0, 0, 1000, 32'd0,
              make_result(afd_pkg::PH_IDLE, 0, 0, 0, 0));
    add_typed(afd_pkg::KIND_CANCEL, 0, 0, 0, 32'd5,
              make_result(afd_pkg::PH_IDLE, 0, 0, 0, 0));
    add_typed(KIND_UNKNOWN, 0, 0, 0, 32'd6, make_result(afd_pkg::PH_IDLE, 0, 0, 0, 0));
    add_typed(afd_pkg::KIND_CLEAR, 0, 0, 0, 32'd7,
              make_result(afd_pkg::PH_IDLE, 0, 0, 0, 0));
    // A free fall that ends too soon.
    add_typed(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd10,
              make_result(afd_pkg::PH_FREE, 0, 0, 0, 0));
    add_typed(afd_pkg::KIND_SAMPLE, 0, 0, 1000, 32'd20,
              make_result(afd_pkg::PH_IDLE, 0, 0, 0, 0));
    // Recovery from free fall without an impact.
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd100);
    add_typed(afd_pkg::KIND_SAMPLE, 0, 0, 1000, 32'd300,
              make_result(afd_pkg::PH_IDLE, 0, 0, 0, 0));
    // A free fall that outlasts its timeout.
    add_row(afd_pkg::KIND_SAMPLE, 10, -10, 5, 32'd400);
    add_typed(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd4000,
              make_result(afd_pkg::PH_IDLE, 0, 0, 0, 0));
    // A full fall with extreme axes, confirmed, then cancelled by the user.
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd5000);
    add_typed(afd_pkg::KIND_SAMPLE, -32768, 32767, -32768, 32'd5100,
              make_result(afd_pkg::PH_IMPACT, 0, 0, 0, 16'sd32767));
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd5200);
    add_row(afd_pkg::KIND_SAMPLE, 100, 0, 0, 32'd6000);
    add_typed(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd7200,
              make_result(afd_pkg::PH_CONF, 1, 0, 1, 16'sd32767));
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd8000);
    add_typed(afd_pkg::KIND_CANCEL, 0, 0, 0, 32'd8100,
              make_result(afd_pkg::PH_CANC, 0, 1, 1, 16'sd32767));
    // A cancel outside the confirmed state is ignored; the next sample
    // leaves the cancelled state.
    add_row(afd_pkg::KIND_CANCEL, 0, 0, 0, 32'd8150);
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd8200);
    // Free fall across the timestamp wrap, then a negative peak and an impact
    // window that runs out.
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'hFFFF_FFF0);
    add_typed(afd_pkg::KIND_SAMPLE, -32768, -32768, -32768, 32'h0000_0060,
              make_result(afd_pkg::PH_IMPACT, 0, 0, 1, 16'sh8000));
    add_typed(afd_pkg::KIND_SAMPLE, 0, 0, 3000, 32'd696,
              make_result(afd_pkg::PH_IDLE, 0, 0, 1, 16'sh8000));
    add_typed(afd_pkg::KIND_CLEAR, 0, 0, 0, 32'd700,
              make_result(afd_pkg::PH_IDLE, 0, 0, 0, 16'sh8000));
    // A weaker impact leaves the peak alone, then the stillness is lost.
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd800);
    add_row(afd_pkg::KIND_SAMPLE, 0, 3000, 0, 32'd900);
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd950);
    add_row(afd_pkg::KIND_SAMPLE, 0, 0, 1500, 32'd1000);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    // Random phases, each under its own register setting.
    write_moderate();
    run_random(60);
    drain();

    // Everything at zero: nothing is below a zero threshold.
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(25);
    drain();

    // Largest thresholds (bit 15 of the word must be dropped) and zero times.
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(60);
    drain();

    // Every register at its largest value.
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF);
    run_random(60);
    drain();

    // A stretch with no idling on either side.
    calm = 1'b1;
    write_moderate();
    run_random(60);
    drain();
    calm = 1'b0;

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(60);
    drain();

    write_moderate();
    run_random(60);
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
